// ===== sv/acf_pkg.sv =====
// Shared types, constants and character tables for the ASCII hex command framer.
// No dependencies; used by every module of the framer.
package acf_pkg;

	// Framing characters
	localparam logic [7:0] CHR_STX = 8'h02;
	localparam logic [7:0] CHR_ETX = 8'h03;
	localparam logic [7:0] CHR_CR  = 8'h0D;

	// Command codes
	localparam logic [2:0] OP_HOF = 3'd0;
	localparam logic [2:0] OP_HON = 3'd1;
	localparam logic [2:0] OP_HRE = 3'd2;
	localparam logic [2:0] OP_HBV = 3'd3;
	localparam logic [2:0] OP_HGV = 3'd4;
	localparam logic [2:0] OP_HGC = 3'd5;
	localparam logic [2:0] OP_HPO = 3'd6;
	localparam logic [2:0] OP_HGS = 3'd7;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// Classified command, as held in the queue
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] value;
		logic [2:0]  ndig;   // value digits to send, 0..4
		logic [7:0]  csum;   // frame checksum
	} acf_desc_t;

	// Letter k (0..2) of the command chosen by op
	function automatic logic [7:0] cmd_letter(input logic [2:0] op, input logic [1:0] k);
		logic [7:0] c2;
		c2 = "H";
		unique case (op)
			OP_HOF:  c2 = "F";
			OP_HON:  c2 = "N";
			OP_HRE:  c2 = "E";
			OP_HBV:  c2 = "V";
			OP_HGV:  c2 = "V";
			OP_HGC:  c2 = "C";
			OP_HPO:  c2 = "O";
			OP_HGS:  c2 = "S";
			default: c2 = "S";
		endcase
		unique case (k)
			2'd0: return "H";
			2'd1: begin
				unique case (op)
					OP_HOF, OP_HON: return "O";
					OP_HRE:         return "R";
					OP_HBV:         return "B";
					OP_HPO:         return "P";
					default:        return "G";
				endcase
			end
			default: return c2;
		endcase
	endfunction

	function automatic logic [7:0] hex_lower(input logic [3:0] nib);
		return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("a") + 8'(nib - 4'd10);
	endfunction

	function automatic logic [7:0] hex_upper(input logic [3:0] nib);
		return (nib < 4'd10) ? 8'("0") + 8'(nib) : 8'("A") + 8'(nib - 4'd10);
	endfunction

endpackage

// ===== sv/ascii_hex_command_framer_unit.sv =====
// ASCII hex command framer: STX, command letters, optional hex value, ETX,
// two-digit checksum, CR. The first byte passes the queue, sequencer and output register.
// Throughput: one frame byte per cycle while out_ready holds, so a command takes
// 8 to 12 bytes (8 plus the value digits).
// Commands queue up while a frame drains; the next frame follows with no gap.
// Reset clears the queue, the sequencer and the output valid.
module ascii_hex_command_framer_unit import acf_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic        last
);

	acf_desc_t front_desc;
	acf_desc_t q_desc;
	logic      q_full;
	logic      q_valid;
	logic      q_pop;

	acf_front u_front (
		.op    (op),
		.value (value),
		.desc  (front_desc)
	);

	assign in_ready = !q_full;

	acf_queue #(.Depth(QueueDepth)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (in_valid && !q_full),
		.wr_desc  (front_desc),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_desc  (q_desc)
	);

	acf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_desc     (q_desc),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last       (last)
	);

endmodule

// ===== sv/acf_front.sv =====
// Front end of the framer: classifies a command and precomputes its checksum.
// Depends on acf_pkg.
module acf_front import acf_pkg::*; (
	input  logic [2:0]  op,
	input  logic [15:0] value,
	output acf_desc_t   desc
);

	logic [2:0] ndig;
	logic [7:0] sum;

	// Number of hex digits sent: only for set-voltage with a nonzero value
	always_comb begin
		ndig = 3'd0;
		if (op == OP_HBV) begin
			priority if (value[15:12] != 4'd0) ndig = 3'd4;
			else if (value[11:8] != 4'd0)      ndig = 3'd3;
			else if (value[7:4] != 4'd0)       ndig = 3'd2;
			else if (value[3:0] != 4'd0)       ndig = 3'd1;
			else                               ndig = 3'd0;
		end
	end

	// Checksum: framing, letters and sent digits, modulo 256
	always_comb begin
		sum = CHR_STX + CHR_ETX + cmd_letter(op, 2'd0) + cmd_letter(op, 2'd1)
			+ cmd_letter(op, 2'd2);
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < ndig) sum = sum + hex_lower(value[i*4 +: 4]);
		end
	end

	assign desc = '{op: op, value: value, ndig: ndig, csum: sum};

endmodule

// ===== sv/acf_queue.sv =====
// Small FIFO of classified commands between the front and back ends.
// Depends on acf_pkg.
module acf_queue import acf_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  acf_desc_t wr_desc,
	output logic      full,
	input  logic      rd_en,
	output logic      rd_valid,
	output acf_desc_t rd_desc
);

	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	acf_desc_t      mem_q [Depth];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_desc  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_desc;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/acf_back.sv =====
// Back end of the framer: walks a queued command out one frame byte per transfer.
// Depends on acf_pkg.
module acf_back import acf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  acf_desc_t  q_desc,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       last
);

	acf_desc_t  desc_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       emit;
	logic       is_last;
	logic [3:0] etx_pos;
	logic [3:0] nib_idx;
	logic [7:0] nxt_byte;

	assign etx_pos = 4'd4 + 4'(desc_q.ndig);
	assign is_last = (idx_q == etx_pos + 4'd3);
	assign emit    = busy_q && (!out_valid_q || out_ready);
	assign q_pop   = q_valid && (!busy_q || (emit && is_last));
	assign nib_idx = 4'(desc_q.ndig) + 4'd3 - idx_q;

	// Byte at the current frame position
	always_comb begin
		priority if (idx_q == 4'd0)       nxt_byte = CHR_STX;
		else if (idx_q < 4'd4)            nxt_byte = cmd_letter(desc_q.op, idx_q[1:0] - 2'd1);
		else if (idx_q < etx_pos)         nxt_byte = hex_lower(desc_q.value[nib_idx[1:0]*4 +: 4]);
		else if (idx_q == etx_pos)        nxt_byte = CHR_ETX;
		else if (idx_q == etx_pos + 4'd1) nxt_byte = hex_upper(desc_q.csum[7:4]);
		else if (idx_q == etx_pos + 4'd2) nxt_byte = hex_upper(desc_q.csum[3:0]);
		else                              nxt_byte = CHR_CR;
	end

	// Sequencer: load next command right behind the closing byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 4'd1;
			if (is_last) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) desc_q <= q_desc;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= nxt_byte;
			last_q <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last       = last_q;

endmodule

// ===== bench/framer_checker.sv =====
// Frame checker for the ASCII hex command framer: predicts every frame byte from
// the accepted commands and compares the output channel against it.
// Depends on acf_pkg for command codes and framing characters.
`timescale 1ns / 1ps

module framer_checker import acf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  op,
	input  logic [15:0] value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  frame_byte,
	input  logic        last,
	output int          errors,
	output int          pending,
	output int          commands_seen,
	output int          frames_checked,
	output int          bytes_checked,
	output int          digit_frames
);

	typedef struct packed {
		logic [7:0] data;
		logic       eop;
	} frame_beat_t;

	frame_beat_t expected_beats[$];

	initial begin
		errors = 0;
		pending = 0;
		commands_seen = 0;
		frames_checked = 0;
		bytes_checked = 0;
		digit_frames = 0;
	end

	// ASCII hex digit, lowercase for value digits, uppercase for the checksum
	function automatic logic [7:0] nibble_char(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10)
			return 8'h30 + {4'd0, nib};
		return (upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
	endfunction

	function automatic logic [23:0] command_name(input logic [2:0] c_op);
		case (c_op)
			OP_HOF:  return "HOF";
			OP_HON:  return "HON";
			OP_HRE:  return "HRE";
			OP_HBV:  return "HBV";
			OP_HGV:  return "HGV";
			OP_HGC:  return "HGC";
			OP_HPO:  return "HPO";
			default: return "HGS";
		endcase
	endfunction

	function automatic void push_beat(input logic [7:0] data, input logic eop);
		frame_beat_t beat;
		beat.data = data;
		beat.eop = eop;
		expected_beats.push_back(beat);
	endfunction

	// Build the expected frame for one command and queue its bytes
	task automatic predict_frame(input logic [2:0] c_op, input logic [15:0] c_val);
		logic [7:0]  sum;
		logic [7:0]  ch;
		logic [23:0] name;
		int          top;
		sum = CHR_STX;
		push_beat(CHR_STX, 1'b0);
		name = command_name(c_op);
		for (int i = 2; i >= 0; i--) begin
			ch = name[i*8 +: 8];
			push_beat(ch, 1'b0);
			sum += ch;
		end
		// value digits only for set-voltage with a nonzero code, no leading zeros
		if (c_op == OP_HBV && c_val != 16'd0) begin
			top = 3;
			while (top > 0 && c_val[top*4 +: 4] == 4'd0)
				top--;
			for (int i = top; i >= 0; i--) begin
				ch = nibble_char(c_val[i*4 +: 4], 1'b0);
				push_beat(ch, 1'b0);
				sum += ch;
			end
			digit_frames++;
		end
		push_beat(CHR_ETX, 1'b0);
		sum += CHR_ETX;
		push_beat(nibble_char(sum[7:4], 1'b1), 1'b0);
		push_beat(nibble_char(sum[3:0], 1'b1), 1'b0);
		push_beat(CHR_CR, 1'b1);
	endtask

	// Output side is checked before the input side: a byte leaving at this edge
	// cannot depend on a command accepted at the same edge.
	always @(posedge clk) begin
		frame_beat_t beat;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected frame byte %h (last=%b)", frame_byte, last);
					errors++;
				end else begin
					beat = expected_beats.pop_front();
					bytes_checked++;
					if (frame_byte !== beat.data) begin
						$error("frame_byte mismatch: expected %h, got %h",
							beat.data, frame_byte);
						errors++;
					end
					if (last !== beat.eop) begin
						$error("last mismatch: expected %b, got %b", beat.eop, last);
						errors++;
					end
					if (beat.eop)
						frames_checked++;
				end
			end
			if (in_valid && in_ready) begin
				predict_frame(op, value);
				commands_seen++;
			end
			pending = expected_beats.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the framer testbench: clock, reset, command stimulus, output stalls,
// watchdog and verdict. Depends on acf_pkg, framer_checker and the framer RTL.
`timescale 1ns / 1ps

module testbench;
	import acf_pkg::*;

	localparam int IDLE_PCT      = 36;
	localparam int RANDOM_CMDS   = 360;
	localparam int STALL_LIMIT   = 1000;
	localparam int DRAIN_CYCLES  = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = OP_HOF;
	logic [15:0] value = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  frame_byte;
	logic        last;

	int errors;
	int pending;
	int commands_seen;
	int frames_checked;
	int bytes_checked;
	int digit_frames;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ascii_hex_command_framer_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last       (last)
	);

	framer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_byte     (frame_byte),
		.last           (last),
		.errors         (errors),
		.pending        (pending),
		.commands_seen  (commands_seen),
		.frames_checked (frames_checked),
		.bytes_checked  (bytes_checked),
		.digit_frames   (digit_frames)
	);

	// Receiver stalls at random, except during the no-idle stretch
	always @(posedge clk) begin
		out_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// One command transfer; valid stays up across back-to-back commands
	task automatic send_command(input logic [2:0] c_op, input logic [15:0] c_val);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= c_op;
		value <= c_val;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic logic [15:0] random_value();
		case ($urandom_range(5))
			0:       return 16'd0;
			1:       return 16'($urandom_range(1, 15));
			2:       return 16'($urandom_range(16, 255));
			3:       return 16'($urandom_range(256, 4095));
			4:       return 16'($urandom_range(4096, 65535));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [2:0]  all_ops[8];
		logic [15:0] hbv_values[11];
		logic [2:0]  r_op;

		all_ops = '{OP_HOF, OP_HON, OP_HRE, OP_HBV, OP_HGV, OP_HGC, OP_HPO, OP_HGS};
		// digit-count boundaries, all-ones, top bit, and 0xAAA whose sum wraps below 0x10
		hbv_values = '{16'h0000, 16'h0001, 16'h000F, 16'h0010, 16'h00FF, 16'h0100,
			16'h0AAA, 16'h1000, 16'h8000, 16'hABCD, 16'h0F0F};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every command with a full value (ignored except for HBV),
		// then set-voltage across digit counts, plus an op with a zero value
		foreach (all_ops[k])
			send_command(all_ops[k], 16'hFFFF);
		foreach (hbv_values[k])
			send_command(OP_HBV, hbv_values[k]);
		send_command(OP_HGS, 16'd0);

		// Random commands, set-voltage weighted up; one stretch with no idling
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			idle_on = !(n >= 120 && n < 220);
			r_op = ($urandom_range(99) < 40) ? OP_HBV : 3'($urandom_range(7));
			send_command(r_op, random_value());
		end
		idle_on = 1'b1;
		in_valid <= 1'b0;

		// let the checker take in the last command before watching its backlog
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d commands, %0d frames and %0d bytes checked;",
			commands_seen, frames_checked, bytes_checked);
		$display("  %0d set-voltage frames carried value digits", digit_frames);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
